### src/ibpd_pkg.sv
// Shared types, codes and reset values for the interlocked button pair debouncer.
// Used by the top level; depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package ibpd_pkg;

  // Counter width default and register reset values.
  localparam int unsigned CountWidthDefault = 16;
  localparam int unsigned DelayWidth        = 16;
  localparam logic [DelayWidth-1:0] DelayReset = 16'd10;

  // Configuration register indexes.
  localparam logic RegDebounceDelay = 1'b0;
  localparam logic RegLocalMode     = 1'b1;

  // Event codes.
  localparam logic [1:0] EvOpenReleased  = 2'd0;
  localparam logic [1:0] EvOpenPressed   = 2'd1;
  localparam logic [1:0] EvCloseReleased = 2'd2;
  localparam logic [1:0] EvClosePressed  = 2'd3;

  // Action codes.
  localparam logic [1:0] ActEmergencyStop = 2'd0;
  localparam logic [1:0] ActValveClose    = 2'd1;
  localparam logic [1:0] ActValveOpen     = 2'd2;

  // One result item as it waits in the output queue.
  typedef struct packed {
    logic       last_event;
    logic [1:0] action_code;
    logic       action_valid;
    logic [1:0] event_code;
  } result_t;

  // Builds a result item; action fields apply only in local mode.
  function automatic result_t make_result(input logic [1:0] code, input logic local_mode,
                                          input logic last);
    result_t r;
    r.event_code   = code;
    r.action_valid = local_mode;
    r.last_event   = last;
    r.action_code  = ActEmergencyStop;
    if (local_mode) begin
      if (code == EvOpenPressed) begin
        r.action_code = ActValveClose;
      end else if (code == EvClosePressed) begin
        r.action_code = ActValveOpen;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

### src/interlocked_button_pair_debounce.sv
// Top level of the interlocked open/close button debouncer with its output queue.
// Depends on ibpd_pkg for codes, reset values and the result type.
`timescale 1ns / 1ps
`default_nettype none

// Each accepted request is one sampled tick of the open and close button levels.
// A tick is taken at once: both debouncers update in the cycle of acceptance
// and the zero, one or two events it causes go into a four-entry output queue,
// which drains one event per cycle while the output side is ready. The input
// side is ready whenever the queue has room for two events, so ticks are
// accepted every cycle as long as the output side takes events about as fast
// as they appear. When both buttons flip on the same tick, the open event comes
// first and only the second carries tlast. Holding both buttons freezes both
// debouncers. Configuration writes take effect at the next clock edge.
module interlocked_button_pair_debounce #(
  parameter int unsigned COUNT_WIDTH = ibpd_pkg::CountWidthDefault
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // Configuration write port.
  input  wire logic                            cfg_we_i,
  input  wire logic                            cfg_index_i,
  input  wire logic [ibpd_pkg::DelayWidth-1:0] cfg_data_i,
  // Tick input.
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  input  wire logic [7:0]                      s_axis_tdata,  // [0] open_button, [1] close_button
  // Event output.
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // [1:0] event_code, [2] action_valid, [4:3] action_code
  output      logic [7:0]                      m_axis_tdata,
  output      logic                            m_axis_tlast
);

  localparam int unsigned CmpWidth =
      (COUNT_WIDTH > ibpd_pkg::DelayWidth) ? COUNT_WIDTH : ibpd_pkg::DelayWidth;
  localparam int unsigned QDepth = 4;
  localparam int unsigned PtrW   = 2;

  // Configuration registers.
  logic [ibpd_pkg::DelayWidth-1:0] delay_q;
  logic                            local_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= ibpd_pkg::DelayReset;
      local_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ibpd_pkg::RegDebounceDelay: delay_q <= cfg_data_i;
        ibpd_pkg::RegLocalMode:     local_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Debouncer state.
  logic                   open_deb_q, open_deb_d, close_deb_q, close_deb_d;
  logic [COUNT_WIDTH-1:0] open_cnt_q, open_cnt_d, close_cnt_q, close_cnt_d;

  logic accept;
  logic op, cl, examine;
  logic [COUNT_WIDTH-1:0] open_inc, close_inc;
  logic open_fire, close_fire;

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign op      = s_axis_tdata[0];
  assign cl      = s_axis_tdata[1];
  assign examine = !op || !cl;
  assign open_inc  = open_cnt_q + COUNT_WIDTH'(1);
  assign close_inc = close_cnt_q + COUNT_WIDTH'(1);

  // A button fires when its level has differed long enough.
  assign open_fire  = examine && (op != open_deb_q) &&
                      (CmpWidth'(open_inc) >= CmpWidth'(delay_q));
  assign close_fire = examine && (cl != close_deb_q) &&
                      (CmpWidth'(close_inc) >= CmpWidth'(delay_q));

  // Next debouncer state for the open button.
  always_comb begin
    open_deb_d = open_deb_q;
    open_cnt_d = open_cnt_q;
    if (accept && examine) begin
      if (op != open_deb_q) begin
        if (open_fire) begin
          open_cnt_d = '0;
          open_deb_d = op;
        end else begin
          open_cnt_d = open_inc;
        end
      end else begin
        open_cnt_d = '0;
      end
    end
  end

  // Next debouncer state for the close button.
  always_comb begin
    close_deb_d = close_deb_q;
    close_cnt_d = close_cnt_q;
    if (accept && examine) begin
      if (cl != close_deb_q) begin
        if (close_fire) begin
          close_cnt_d = '0;
          close_deb_d = cl;
        end else begin
          close_cnt_d = close_inc;
        end
      end else begin
        close_cnt_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_deb_q  <= 1'b0;
      open_cnt_q  <= '0;
      close_deb_q <= 1'b0;
      close_cnt_q <= '0;
    end else begin
      open_deb_q  <= open_deb_d;
      open_cnt_q  <= open_cnt_d;
      close_deb_q <= close_deb_d;
      close_cnt_q <= close_cnt_d;
    end
  end

  // Events of this tick, open first, tlast on the final one.
  ibpd_pkg::result_t res_open, res_close, slot0, slot1;
  logic [1:0]        push_n;

  assign res_open  = ibpd_pkg::make_result(op ? ibpd_pkg::EvOpenPressed
                                              : ibpd_pkg::EvOpenReleased,
                                           local_q, !close_fire);
  assign res_close = ibpd_pkg::make_result(cl ? ibpd_pkg::EvClosePressed
                                              : ibpd_pkg::EvCloseReleased,
                                           local_q, 1'b1);
  assign slot0  = open_fire ? res_open : res_close;
  assign slot1  = res_close;
  assign push_n = accept ? ({1'b0, open_fire} + {1'b0, close_fire}) : 2'd0;

  // Output queue: up to two writes and one read per cycle.
  ibpd_pkg::result_t q_mem [QDepth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PtrW:0]     fill_q, fill_d;
  logic              pop;

  assign pop           = m_axis_tvalid && m_axis_tready;
  assign m_axis_tvalid = (fill_q != '0);
  assign s_axis_tready = (fill_q <= (PtrW+1)'(QDepth - 2));
  assign fill_d        = fill_q + (PtrW+1)'(push_n) - (PtrW+1)'(pop);

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      q_mem[wr_ptr_q] <= slot0;
    end
    if (push_n == 2'd2) begin
      q_mem[wr_ptr_q + PtrW'(1)] <= slot1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PtrW'(push_n);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop);
      fill_q   <= fill_d;
    end
  end

  // Output payload from the queue head.
  ibpd_pkg::result_t head;
  assign head         = q_mem[rd_ptr_q];
  assign m_axis_tdata = {3'b000, head.action_code, head.action_valid, head.event_code};
  assign m_axis_tlast = head.last_event;

endmodule

`default_nettype wire
